@@ rtl/core/gf16cm_pkg.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) constant multiply - shared package
// Field arithmetic, register map and default sizing for the region multiplier.
// ----------------------------------------------------------------------------
package gf16cm_pkg;

    // Field width and the low part of the reducing polynomial x^16+x^12+x^3+x+1
    localparam int unsigned GF_BITS        = 16;
    localparam logic [15:0] GF_POLY_LOW    = 16'h100B;

    // Lanes per request by default
    localparam int unsigned LANES_DEFAULT  = 4;

    // Configuration register map (word index taken from paddr[2])
    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;
    localparam logic        REG_COEFF_IDX  = 1'b0;
    localparam logic [15:0] COEFF_RESET    = 16'h0001;

    typedef logic [GF_BITS-1:0] gf_elem_t;

    // Carry-less 16x16 product: independent partial products folded by XOR
    function automatic logic [31:0] clmul16(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ ({16'h0000, a} << i);
            end
        end
        return acc;
    endfunction

    // Multiply in GF(2^16); four folds bring a 31-bit product below degree 16
    function automatic gf_elem_t gf_mul(input gf_elem_t x, input gf_elem_t y);
        logic [31:0] r;
        r = clmul16(x, y);
        for (int f = 0; f < 4; f++)
        begin
            r = {16'h0000, r[15:0]} ^ clmul16(r[31:16], GF_POLY_LOW);
        end
        return r[15:0];
    endfunction

endpackage

@@ rtl/core/gf16cm_lane.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) constant multiply - lane
// One field multiplier; a disabled lane yields zero.
// ----------------------------------------------------------------------------
module gf16cm_lane
(
    input  gf16cm_pkg::gf_elem_t word,
    input  gf16cm_pkg::gf_elem_t coefficient,
    input  logic                 enable,
    output gf16cm_pkg::gf_elem_t prod
);

    always_comb
    begin
        if (enable)
        begin
            prod = gf16cm_pkg::gf_mul(word, coefficient);
        end
        else
        begin
            prod = '0;
        end
    end

endmodule

@@ rtl/core/gf16cm_out_stage.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) constant multiply - merge and output stage
// Gather the lane products into one result and hold it in a skid buffer.
// ----------------------------------------------------------------------------
module gf16cm_out_stage
#(
    parameter int unsigned LANES = gf16cm_pkg::LANES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    output logic                  in_ready,
    input  logic [16*LANES-1:0]   in_prod,
    input  logic [LANES-1:0]      in_mask,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [16*LANES-1:0]   out_prod,
    output logic [LANES-1:0]      out_mask,
    output logic                  out_last
);

    localparam int unsigned PAY_W = 16*LANES + LANES + 1;

    logic             main_valid_reg;
    logic             main_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [PAY_W-1:0] main_pay_reg;
    logic [PAY_W-1:0] main_pay_next;
    logic [PAY_W-1:0] skid_pay_reg;
    logic [PAY_W-1:0] skid_pay_next;
    logic [PAY_W-1:0] in_pay;
    logic             advance;

    assign in_pay   = {in_last, in_mask, in_prod};
    assign in_ready = ~skid_valid_reg;
    assign advance  = ~main_valid_reg | out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_pay_next   = main_pay_reg;
        skid_pay_next   = skid_pay_reg;
        if (advance)
        begin
            if (skid_valid_reg)
            begin
                // drain the parked request first
                main_pay_next   = skid_pay_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_pay_next   = in_pay;
                main_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_pay_next   = in_pay;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_pay_reg <= main_pay_next;
        skid_pay_reg <= skid_pay_next;
    end

    assign out_valid = main_valid_reg;
    assign out_prod  = main_pay_reg[16*LANES-1:0];
    assign out_mask  = main_pay_reg[16*LANES +: LANES];
    assign out_last  = main_pay_reg[PAY_W-1];

endmodule

@@ rtl/core/gf16_region_const_multiply.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) region multiply by a constant
// Top level: lanes of field multipliers, merge/skid stage and APB register.
// ----------------------------------------------------------------------------
// Every request on the slave stream carries LANES 16-bit field elements in
// tdata (word 0 in the lowest bits), a lane-valid mask in tuser and a region
// end flag in tlast. Each valid word is multiplied by the programmed
// coefficient in GF(2^16) with reducing polynomial x^16+x^12+x^3+x+1; words
// whose mask bit is clear come out as zero, and mask and last pass through
// unchanged. One result leaves the master stream for each request, in order.
// The block takes one request per clock cycle while s_axis_tready is high;
// all lanes multiply in parallel in the accepting cycle and the result is
// registered, and a two-entry skid buffer at the output keeps s_axis_tready
// high while a single result waits. A request taken while the master side
// stalls parks in the second entry and drops s_axis_tready until it moves up
// to the output register; with no back-pressure the input never stalls.
// The coefficient (reset value 1) sits at APB byte address 0; program it only
// while no request is in flight.
// ----------------------------------------------------------------------------
module gf16_region_const_multiply
#(
    parameter int unsigned LANES = gf16cm_pkg::LANES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gf16cm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gf16cm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gf16cm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [16*LANES-1:0]                 s_axis_tdata,  // in_word0, in_word1, ...
    input  logic [LANES-1:0]                    s_axis_tuser,  // in_lane_mask
    input  logic                                s_axis_tlast,
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [16*LANES-1:0]                 m_axis_tdata,  // out_prod0, out_prod1, ...
    output logic [LANES-1:0]                    m_axis_tuser,  // out_lane_mask
    output logic                                m_axis_tlast
);

    gf16cm_pkg::gf_elem_t coeff_reg;
    gf16cm_pkg::gf_elem_t coeff_next;
    logic                 cfg_write;
    logic                 coeff_sel;
    logic                 in_fire;
    logic [16*LANES-1:0]  lane_prod;

    // ------------------------------------------------------------------
    // Configuration register: write on the access phase, read returns
    // the coefficient zero-extended, other addresses read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign coeff_sel = (paddr[2] == gf16cm_pkg::REG_COEFF_IDX);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_write && coeff_sel)
        begin
            coeff_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= gf16cm_pkg::COEFF_RESET;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign prdata = coeff_sel ? {16'h0000, coeff_reg} : '0;

    // ------------------------------------------------------------------
    // Lanes: one multiplier per word, gated by its mask bit.
    // ------------------------------------------------------------------
    assign in_fire = s_axis_tvalid & s_axis_tready;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        gf16cm_lane u_lane
        (
            .word        (s_axis_tdata[16*k +: 16]),
            .coefficient (coeff_reg),
            .enable      (s_axis_tuser[k]),
            .prod        (lane_prod[16*k +: 16])
        );
    end

    // ------------------------------------------------------------------
    // Merge the lane products with mask and last into one result and
    // hold it until the master side takes it.
    // ------------------------------------------------------------------
    gf16cm_out_stage #(.LANES(LANES)) u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (s_axis_tready),
        .in_prod   (lane_prod),
        .in_mask   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_prod  (m_axis_tdata),
        .out_mask  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ rtl/core/gf16cm_checker.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) constant multiply - port checker
// Temporal checks on the top-level ports, bound to every instance.
// ----------------------------------------------------------------------------
module gf16cm_checker
#(
    parameter int unsigned LANES = gf16cm_pkg::LANES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gf16cm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gf16cm_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [gf16cm_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                                pready,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [16*LANES-1:0]                 m_axis_tdata,
    input  logic [LANES-1:0]                    m_axis_tuser,
    input  logic                                m_axis_tlast
);

    logic [16*LANES-1:0] lane_bits;

    for (genvar k = 0; k < LANES; k++)
    begin : g_bits
        assign lane_bits[16*k +: 16] = {16{m_axis_tuser[k]}};
    end

    // stalled result keeps valid and payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // masked-off lanes carry zero
    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & ~lane_bits) == '0))
        else $error("masked lane not zero");

    // after an accepted request a result is valid on the next cycle
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    // input back-pressure only follows an output stall
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("tready dropped without output stall");

    // a coefficient write is read back
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
            && (paddr[2] == gf16cm_pkg::REG_COEFF_IDX)
        |=> (paddr[2] != gf16cm_pkg::REG_COEFF_IDX)
            || (prdata[15:0] == $past(pwdata[15:0])))
        else $error("coefficient readback mismatch");

endmodule

bind gf16_region_const_multiply gf16cm_checker #(.LANES(LANES)) u_gf16cm_checker (.*);

@@ verif/gf16_region_const_multiply_test.sv @@
// ----------------------------------------------------------------------------
// GF(2^16) region constant multiply - block testbench
// Streams region requests through the multiplier under shifting back-pressure
// and checks every result against a bit-level product computed alongside.
// ----------------------------------------------------------------------------
module gf16_region_const_multiply_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_LANES   = 4;
    localparam int unsigned DRAIN_WAIT  = 4;     // settle wait once no result is owed
    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer anywhere

    // Register byte addresses: the coefficient and an unmapped word
    localparam logic [gf16cm_pkg::APB_ADDR_W-1:0] COEFF_ADDR  =
        {gf16cm_pkg::REG_COEFF_IDX, 2'b00};
    localparam logic [gf16cm_pkg::APB_ADDR_W-1:0] UNUSED_ADDR =
        {~gf16cm_pkg::REG_COEFF_IDX, 2'b00};

    // One request: words in lane order, lane 0 in the lowest bits
    typedef struct packed {
        logic [NUM_LANES-1:0][15:0] word;
        logic [NUM_LANES-1:0]       lane_mask;
        logic                       last;
    } region_beat_t;

    // One result: the products with mask and last carried through
    typedef struct packed {
        logic [NUM_LANES-1:0][15:0] prod;
        logic [NUM_LANES-1:0]       lane_mask;
        logic                       last;
    } product_beat_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   psel = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite = 1'b0;
    logic [gf16cm_pkg::APB_ADDR_W-1:0]      paddr = '0;
    logic [gf16cm_pkg::APB_DATA_W-1:0]      pwdata = '0;
    logic [gf16cm_pkg::APB_DATA_W-1:0]      prdata;
    logic                                   pready;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [16*NUM_LANES-1:0]                s_axis_tdata = '0;  // in_word0 .. in_word3
    logic [NUM_LANES-1:0]                   s_axis_tuser = '0;  // in_lane_mask
    logic                                   s_axis_tlast = 1'b0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [16*NUM_LANES-1:0]                m_axis_tdata;       // out_prod0 .. out_prod3
    logic [NUM_LANES-1:0]                   m_axis_tuser;       // out_lane_mask
    logic                                   m_axis_tlast;

    // Shadow of the coefficient register and the results still owed
    logic [15:0]     coeff_shadow = gf16cm_pkg::COEFF_RESET;
    product_beat_t   pending_products[$];
    product_beat_t   owed;
    product_beat_t   seen;
    int              fault_count = 0;
    int unsigned     stall_cycles = 0;
    int unsigned     src_idle_pct = 0;
    int unsigned     sink_idle_pct = 0;

    gf16_region_const_multiply
    #(
        .LANES(NUM_LANES)
    )
    DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Shift-and-add product: walk the bits of b, doubling a each step and
    // folding the x^16 term back in with the low part of the polynomial.
    function automatic logic [15:0] gf16_times(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] acc;
        logic [15:0] run;
        acc = '0;
        run = a;
        for (int i = 0; i < 16; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ run;
            end
            run = run[15] ? ((run << 1) ^ gf16cm_pkg::GF_POLY_LOW) : (run << 1);
        end
        return acc;
    endfunction

    // Masked-off lanes come out as zero; mask and last pass straight through
    function automatic product_beat_t region_products(input region_beat_t beat,
                                                      input logic [15:0] coeff);
        product_beat_t res;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            res.prod[k] = beat.lane_mask[k] ? gf16_times(beat.word[k], coeff) : 16'h0000;
        end
        res.lane_mask = beat.lane_mask;
        res.last      = beat.last;
        return res;
    endfunction

    // Bias the words towards the edges of the field: zero, all ones, one-hot
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one request, idling beforehand at the current sender rate, and
    // hold it until the block takes it. tvalid is left high on exit so that
    // back-to-back requests need no second assignment in the same step.
    task automatic send_request(input region_beat_t beat);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.word;
        s_axis_tuser  <= beat.lane_mask;
        s_axis_tlast  <= beat.last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        pending_products.push_back(region_products(beat, coeff_shadow));
    endtask

    // Drop the request stream and wait until every owed result has left
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write a register once the block is idle, then read the coefficient back
    task automatic program_register(input logic [gf16cm_pkg::APB_ADDR_W-1:0] addr,
                                    input logic [gf16cm_pkg::APB_DATA_W-1:0] value);
        wait_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        // Only the coefficient word is mapped; anything else must be dropped
        if (addr == COEFF_ADDR)
        begin
            coeff_shadow = value[15:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= COEFF_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata[15:0] !== coeff_shadow)
        begin
            $error("coefficient: expected %h, got %h", coeff_shadow, prdata[15:0]);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic region_beat_t make_beat(input logic [15:0] w0, input logic [15:0] w1,
                                               input logic [15:0] w2, input logic [15:0] w3,
                                               input logic [3:0] lane_mask, input logic last);
        region_beat_t beat;
        beat.word      = {w3, w2, w1, w0};
        beat.lane_mask = lane_mask;
        beat.last      = last;
        return beat;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the coefficient is one, so every valid word passes unchanged
    task automatic test_reset_coefficient();
        send_request(make_beat(16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 4'hF, 1'b0));
        send_request(make_beat(16'h1234, 16'hABCD, 16'h5A5A, 16'hC3C3, 4'h5, 1'b0));
        send_request(make_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0, 1'b1));
    endtask

    // Doubling pushes the top bit out, which forces the polynomial fold;
    // walk one valid lane at a time to catch lane swaps
    task automatic test_reduction_and_lanes();
        program_register(COEFF_ADDR, 32'h0000_0002);
        send_request(make_beat(16'h8000, 16'h4000, 16'hC000, 16'hFFFF, 4'h1, 1'b0));
        send_request(make_beat(16'h8000, 16'h4000, 16'hC000, 16'hFFFF, 4'h2, 1'b0));
        send_request(make_beat(16'h8000, 16'h4000, 16'hC000, 16'hFFFF, 4'h4, 1'b0));
        send_request(make_beat(16'h8000, 16'h4000, 16'hC000, 16'hFFFF, 4'h8, 1'b1));
    endtask

    // A zero coefficient clears every product, whatever the words
    task automatic test_zero_coefficient();
        program_register(COEFF_ADDR, 32'h0000_0000);
        send_request(make_beat(16'hFFFF, 16'h8001, 16'h0001, 16'h7FFF, 4'hF, 1'b0));
        send_request(make_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1));
    endtask

    // Largest coefficient against the extremes of the words
    task automatic test_full_coefficient();
        program_register(COEFF_ADDR, 32'h0000_FFFF);
        send_request(make_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b0));
        send_request(make_beat(16'h0001, 16'h8000, 16'h0000, 16'h100B, 4'hF, 1'b0));
        send_request(make_beat(16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 4'hA, 1'b0));
        send_request(make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b1));
    endtask

    // The unmapped word must leave the coefficient alone; upper write bits
    // of the mapped word are dropped
    task automatic test_register_map();
        program_register(UNUSED_ADDR, 32'h0000_1234);
        send_request(make_beat(16'h1357, 16'h2468, 16'h8421, 16'hFEDC, 4'hF, 1'b0));
        program_register(COEFF_ADDR, 32'hABCD_0003);
        send_request(make_beat(16'h1357, 16'h2468, 16'h8421, 16'hFEDC, 4'hF, 1'b1));
    endtask

    // Random regions: mostly full lanes, some ragged masks, a fresh
    // coefficient for every stretch
    task automatic test_random_regions(input int unsigned stretches,
                                       input int unsigned requests_per_stretch);
        int unsigned left;
        int unsigned run_len;
        region_beat_t beat;
        for (int s = 0; s < stretches; s++)
        begin
            program_register(COEFF_ADDR, $urandom());
            left = requests_per_stretch;
            while (left != 0)
            begin
                run_len = $urandom_range(1, 16);
                if (run_len > left)
                begin
                    run_len = left;
                end
                for (int n = 0; n < run_len; n++)
                begin
                    beat.word[0]   = pick_word();
                    beat.word[1]   = pick_word();
                    beat.word[2]   = pick_word();
                    beat.word[3]   = pick_word();
                    beat.lane_mask = ($urandom_range(0, 3) != 0) ? 4'hF
                                                                 : 4'($urandom_range(0, 15));
                    // Mostly mark only the region end; now and then a stray last
                    beat.last      = (n == run_len - 1) ? ($urandom_range(0, 9) != 0)
                                                        : ($urandom_range(0, 19) == 0);
                    send_request(beat);
                end
                left -= run_len;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare each accepted result against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.prod      = m_axis_tdata;
            seen.lane_mask = m_axis_tuser;
            seen.last      = m_axis_tlast;
            if (pending_products.size() == 0)
            begin
                $error("result with none outstanding: tdata %h tuser %h tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fault_count++;
            end
            else
            begin
                owed = pending_products.pop_front();
                for (int k = 0; k < NUM_LANES; k++)
                begin
                    if (seen.prod[k] !== owed.prod[k])
                    begin
                        $error("out_prod%0d: expected %h, got %h", k, owed.prod[k],
                               seen.prod[k]);
                        fault_count++;
                    end
                end
                if (seen.lane_mask !== owed.lane_mask)
                begin
                    $error("out_lane_mask: expected %h, got %h", owed.lane_mask,
                           seen.lane_mask);
                    fault_count++;
                end
                if (seen.last !== owed.last)
                begin
                    $error("out_last: expected %b, got %b", owed.last, seen.last);
                    fault_count++;
                end
            end
        end
    end

    // Any transfer on either stream or the register port counts as progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles more lightly than the receiver first
        src_idle_pct  = 31;
        sink_idle_pct = 57;
        test_reset_coefficient();
        test_reduction_and_lanes();
        test_zero_coefficient();
        test_full_coefficient();
        test_register_map();
        test_random_regions(3, 140);

        // Swap the pressure round
        src_idle_pct  = 57;
        sink_idle_pct = 31;
        test_random_regions(3, 140);

        // Full rate both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_regions(3, 140);

        wait_until_drained();
        if (fault_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
